/* src/sphere_overlap_bitmask_assert.svh */
// Assertion macros shared by the sphere overlap bitmask RTL
`ifndef SPHERE_OVERLAP_BITMASK_ASSERT_SVH
`define SPHERE_OVERLAP_BITMASK_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SPHOV_ASSERT(label, clock, reset_n, prop) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
		else $error("sphov assertion failed");
// Check that a condition never holds outside reset
`define SPHOV_ASSERT_NEVER(label, clock, reset_n, cond) \
	label: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
		else $error("sphov forbidden condition seen");
`else
`define SPHOV_ASSERT(label, clock, reset_n, prop)
`define SPHOV_ASSERT_NEVER(label, clock, reset_n, cond)
`endif

`endif

/* src/sphov_pkg.sv */
// Shared constants, types and codes for the sphere overlap bitmask block
package sphov_pkg;

	// table and coordinate sizes
	localparam int MAX_ENTRIES = 64;
	localparam int COORD_WIDTH = 24;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);

	// request field widths
	localparam int INDEX_FIELD_W = 6;
	localparam int FLAG_W        = 32;
	localparam int BASE_W        = 6;
	localparam int COUNT_W       = 7;
	localparam int HIT_W         = 32;
	localparam int S_TDATA_W     = 152;
	localparam int M_TDATA_W     = 32;

	// walk bookkeeping widths
	localparam int SPAN_W = $clog2(MAX_ENTRIES + 1);
	localparam int WALK_W = ((COUNT_W > SPAN_W) ? COUNT_W : SPAN_W) + 1;
	localparam int POS_W  = $clog2(HIT_W + MAX_ENTRIES + 1);
	localparam int BIT_W  = $clog2(HIT_W);

	// arithmetic widths: difference, square, sum of three squares
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * COORD_WIDTH + 1;
	localparam int SUM_W  = SQ_W + 2;

	// match mask bits with a special meaning
	localparam int MASK_RANGE_BIT  = 0;
	localparam int MASK_SINGLE_BIT = 5;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	// one stored sphere
	typedef struct packed {
		logic [FLAG_W-1:0]             flags;
		logic signed [COORD_WIDTH-1:0] radius;
		logic signed [COORD_WIDTH-1:0] cz;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic write_entry;
		logic load_query;
		logic step;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic pipe_empty;
		logic out_free;
	} dp_stat_t;

endpackage

/* src/sphov_ram.sv */
// Generic single-write, single-read RAM with registered read data
module sphov_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/sphov_ctrl.sv */
// Controller state machine: accept requests, run the walk, drain and emit
`include "sphere_overlap_bitmask_assert.svh"

module sphov_ctrl
	import sphov_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  cmd_t      command,
	output logic      s_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (command == CMD_QUERY) begin
						cmd.load_query = 1'b1;
						state_d        = ST_WALK;
					end else begin
						cmd.write_entry = 1'b1;
					end
				end
			end
			ST_WALK: begin
				if (stat.walk_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty && stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a new request only ever meets an empty pipeline
	`SPHOV_ASSERT(a_accept_pipe_empty, clk, arst_n, s_tready |-> stat.pipe_empty)
	// no reads are issued once the walk has ended
	`SPHOV_ASSERT(a_drain_no_step, clk, arst_n, (state_q == ST_DRAIN) |-> !cmd.step)

endmodule

/* src/sphov_dp.sv */
// Datapath: sphere table, walk counters, distance pipeline and result register
`include "sphere_overlap_bitmask_assert.svh"

module sphov_dp
	import sphov_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  ctrl_cmd_t                       cmd,
	output dp_stat_t                        stat,
	input  logic [INDEX_FIELD_W-1:0]        entry_index,
	input  logic [FLAG_W-1:0]               flag_bits,
	input  logic signed [COORD_WIDTH-1:0]   pos_x,
	input  logic signed [COORD_WIDTH-1:0]   pos_y,
	input  logic signed [COORD_WIDTH-1:0]   pos_z,
	input  logic signed [COORD_WIDTH-1:0]   extent,
	input  logic [BASE_W-1:0]               range_base,
	input  logic [COUNT_W-1:0]              range_count,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [HIT_W-1:0]                hit_mask
);

	// query registers
	logic [FLAG_W-1:0]             mask_q;
	logic signed [COORD_WIDTH-1:0] px_q;
	logic signed [COORD_WIDTH-1:0] py_q;
	logic signed [COORD_WIDTH-1:0] pz_q;
	logic signed [COORD_WIDTH-1:0] ext_q;
	logic [WALK_W-1:0]             ptr_q;
	logic [WALK_W-1:0]             end_q;
	logic [POS_W-1:0]              pos_q;
	logic [HIT_W-1:0]              result_q;
	logic                          out_valid_q;
	logic [HIT_W-1:0]              out_data_q;

	// query range decode
	logic [WALK_W-1:0] sum_end;
	logic [WALK_W-1:0] walk_end;
	logic [WALK_W-1:0] walk_start;
	logic [POS_W-1:0]  pos_start;

	// table access
	entry_t           wr_entry;
	logic [ENTRY_W-1:0] rd_data;
	entry_t           ent_s1;
	logic             wr_ok;

	// pipeline
	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      live_s1, live_s2, live_s3, live_s4;
	logic [BIT_W-1:0]          bit_s1, bit_s2, bit_s3, bit_s4;
	logic                      match_s2, match_s3, match_s4;
	logic signed [DIFF_W-1:0]  dx_s2, dy_s2, dz_s2, rs_s2;
	logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z, prod_r;
	logic [SQ_W-1:0]           sqx_s3, sqy_s3, sqz_s3, sqr_s3;
	logic [SQ_W:0]             psum_s4;
	logic [SQ_W-1:0]           sqz_s4, sqr_s4;
	logic [SUM_W-1:0]          total_s4;
	logic                      hit_s4;

	// decode start, end and first result bit of a query
	assign sum_end    = WALK_W'(range_base) + WALK_W'(range_count);
	assign walk_start = flag_bits[MASK_RANGE_BIT] ? WALK_W'(range_base) : '0;
	assign pos_start  = flag_bits[MASK_RANGE_BIT] ? POS_W'(range_base[BIT_W-1:0]) : '0;
	always_comb begin
		if (flag_bits[MASK_SINGLE_BIT]) begin
			walk_end = WALK_W'(range_base);
		end else if (sum_end > WALK_W'(MAX_ENTRIES)) begin
			walk_end = WALK_W'(MAX_ENTRIES);
		end else begin
			walk_end = sum_end;
		end
	end

	// table write: drop indices beyond the table
	assign wr_ok           = int'(entry_index) < MAX_ENTRIES;
	assign wr_entry.flags  = flag_bits;
	assign wr_entry.radius = extent;
	assign wr_entry.cz     = pos_z;
	assign wr_entry.cy     = pos_y;
	assign wr_entry.cx     = pos_x;

	sphov_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.write_entry && wr_ok),
		.wr_addr (IDX_W'(entry_index)),
		.wr_data (wr_entry),
		.rd_en   (cmd.step),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign ent_s1 = entry_t'(rd_data);

	// hold the query and advance the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			end_q <= '0;
			pos_q <= '0;
		end else if (cmd.load_query) begin
			ptr_q <= walk_start;
			end_q <= walk_end;
			pos_q <= pos_start;
		end else if (cmd.step) begin
			ptr_q <= ptr_q + 1'b1;
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			mask_q <= flag_bits;
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			ext_q  <= extent;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: result bit position travels with the read
	always_ff @(posedge clk) begin
		live_s1 <= (pos_q[POS_W-1:BIT_W] == '0);
		bit_s1  <= pos_q[BIT_W-1:0];
	end

	// stage 2: flag match, differences and grown radius
	always_ff @(posedge clk) begin
		live_s2  <= live_s1;
		bit_s2   <= bit_s1;
		match_s2 <= (ent_s1.flags & mask_q) == mask_q;
		dx_s2    <= {px_q[COORD_WIDTH-1], px_q} - {ent_s1.cx[COORD_WIDTH-1], ent_s1.cx};
		dy_s2    <= {py_q[COORD_WIDTH-1], py_q} - {ent_s1.cy[COORD_WIDTH-1], ent_s1.cy};
		dz_s2    <= {pz_q[COORD_WIDTH-1], pz_q} - {ent_s1.cz[COORD_WIDTH-1], ent_s1.cz};
		rs_s2    <= {ext_q[COORD_WIDTH-1], ext_q}
			+ {ent_s1.radius[COORD_WIDTH-1], ent_s1.radius};
	end

	// stage 3: squares
	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;
	assign prod_z = dz_s2 * dz_s2;
	assign prod_r = rs_s2 * rs_s2;

	always_ff @(posedge clk) begin
		live_s3  <= live_s2;
		bit_s3   <= bit_s2;
		match_s3 <= match_s2;
		sqx_s3   <= prod_x[SQ_W-1:0];
		sqy_s3   <= prod_y[SQ_W-1:0];
		sqz_s3   <= prod_z[SQ_W-1:0];
		sqr_s3   <= prod_r[SQ_W-1:0];
	end

	// stage 4: partial sum
	always_ff @(posedge clk) begin
		live_s4  <= live_s3;
		bit_s4   <= bit_s3;
		match_s4 <= match_s3;
		psum_s4  <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		sqz_s4   <= sqz_s3;
		sqr_s4   <= sqr_s3;
	end

	// final sum and strict compare
	assign total_s4 = {1'b0, psum_s4} + SUM_W'(sqz_s4);
	assign hit_s4   = valid_s4 && match_s4 && live_s4 && (total_s4 < SUM_W'(sqr_s4));

	// accumulate the hit mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (cmd.load_query) begin
			result_q <= '0;
		end else if (hit_s4) begin
			result_q[bit_s4] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= result_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_mask  = out_data_q;

	// status to the controller
	assign stat.walk_done  = (ptr_q >= end_q);
	assign stat.pipe_empty = !(valid_s1 || valid_s2 || valid_s3 || valid_s4);
	assign stat.out_free   = !out_valid_q || out_ready;

	// the walk pointer never passes the end of the range
	`SPHOV_ASSERT(a_ptr_in_range, clk, arst_n, ptr_q <= end_q)
	// the controller stops reading when the range is exhausted
	`SPHOV_ASSERT(a_step_in_range, clk, arst_n, cmd.step |-> !stat.walk_done)
	// a result leaves only after the last test has been folded in
	`SPHOV_ASSERT_NEVER(a_emit_with_pending, clk, arst_n, cmd.emit && valid_s4)

endmodule

/* src/sphere_overlap_bitmask.sv */
// Top level of the sphere overlap bitmask block: stream ports, controller and datapath
//
// Requests arrive on the s_ group; s_tuser selects a table write (0) or a query (1).
// A write stores one sphere entry in the cycle it is accepted and gives no result.
// A query walks its range of entries, one entry per cycle, through the
// read, difference, square and compare pipeline, then places one 32-bit hit mask
// in the output register of the m_ group.
// Writes are accepted back to back; a query walks its entries through the single
// read port of the sphere table, and no new request is accepted while it walks
// and drains; an empty walk goes straight from the walk state to the drain.
// The next request is accepted as soon as the result sits in the output register,
// even while the receiver stalls; a query that finishes while the previous result
// is still held waits until that result has been taken.
// Reset clears the controller, the walk counters and the output valid flag; the
// sphere table is not cleared and must be written before it is queried.
module sphere_overlap_bitmask
	import sphov_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index[5:0], flag_bits[37:6], pos_x[61:38], pos_y[85:62],
	// pos_z[109:86], extent[133:110], range_base[139:134], range_count[146:140]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// command[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit_mask[31:0]
	output logic [M_TDATA_W-1:0] m_tdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	cmd_t      command;

	// unpack the request
	logic [INDEX_FIELD_W-1:0]      entry_index;
	logic [FLAG_W-1:0]             flag_bits;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] extent;
	logic [BASE_W-1:0]             range_base;
	logic [COUNT_W-1:0]            range_count;

	assign command     = cmd_t'(s_tuser);
	assign entry_index = s_tdata[5:0];
	assign flag_bits   = s_tdata[37:6];
	assign pos_x       = s_tdata[61:38];
	assign pos_y       = s_tdata[85:62];
	assign pos_z       = s_tdata[109:86];
	assign extent      = s_tdata[133:110];
	assign range_base  = s_tdata[139:134];
	assign range_count = s_tdata[146:140];

	sphov_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (command),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sphov_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.entry_index (entry_index),
		.flag_bits   (flag_bits),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.extent      (extent),
		.range_base  (range_base),
		.range_count (range_count),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.hit_mask    (m_tdata)
	);

endmodule

/* dv/sphere_overlap_bitmask_tb.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the sphere overlap bitmask block
module sphere_overlap_bitmask_tb;
	import sphov_pkg::*;

	localparam int ITEM_TARGET    = 1550;
	localparam int QUIET_TAIL     = 250;	// final requests sent with no idling
	localparam int HOLD_AT        = 500;
	localparam int HOLD_SPAN      = 60;
	localparam int DRAIN_AT       = 1000;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 80;
	localparam int REQ_BITS = INDEX_FIELD_W + FLAG_W + 4 * COORD_WIDTH + BASE_W + COUNT_W;

	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] C_ONE = COORD_WIDTH'(256);	// 1.0 in Q16.8
	localparam logic signed [COORD_WIDTH-1:0] C_HALF = COORD_WIDTH'(128);
	localparam logic signed [COORD_WIDTH-1:0] C_ZERO = COORD_WIDTH'(0);

	typedef struct packed {
		cmd_t                          command;
		logic [INDEX_FIELD_W-1:0]      entry_index;
		logic [FLAG_W-1:0]             flag_bits;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] extent;
		logic [BASE_W-1:0]             range_base;
		logic [COUNT_W-1:0]            range_count;
	} request_t;

	typedef struct packed {
		request_t         req;
		bit               known;
		logic [HIT_W-1:0] hit;
	} script_row_t;

	typedef struct {
		bit               known;
		logic [HIT_W-1:0] hit;
	} scripted_hit_t;

	// directed requests; the hit mask is typed in where it is obvious
	localparam script_row_t SCRIPT [20] = '{
		'{'{CMD_WRITE, 6'd0, 32'hFFFF_FFFF, C_ZERO, C_ZERO, C_ZERO, C_ONE, 6'd0, 7'd0},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd1, 32'h0000_0000, C_MAX, C_MIN, C_ZERO, C_MAX, 6'd0, 7'd0},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd2, 32'hAAAA_AAAA, C_MIN, C_MAX, C_MAX, C_MIN, 6'd63, 7'd64},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd31, 32'hFFFF_FFFF, C_ONE, C_ZERO, C_ZERO, C_ONE, 6'd0, 7'd0},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd32, 32'hFFFF_FFFF, C_ZERO, C_ZERO, C_ZERO, C_MAX, 6'd0, 7'd0},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd33, 32'h0000_0021, C_ZERO, C_ZERO, C_ZERO, C_ONE, 6'd0, 7'd0},
			1'b0, 32'h0},
		'{'{CMD_WRITE, 6'd63, 32'h8000_0021, C_ZERO, C_ZERO, -C_ONE, C_ONE, 6'd0, 7'd0},
			1'b0, 32'h0},
		// empty walks: end at base 0, start and end both at the last slot, zero count
		'{'{CMD_QUERY, 6'd0, 32'h0000_0020, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd0, 7'd5},
			1'b1, 32'h0},
		'{'{CMD_QUERY, 6'd63, 32'h0000_0021, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd63, 7'd64},
			1'b1, 32'h0},
		'{'{CMD_QUERY, 6'd0, 32'h0000_0001, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd63, 7'd0},
			1'b1, 32'h0},
		// point at the centre, point on the surface, negative grown radius
		'{'{CMD_QUERY, 6'd0, 32'h0000_0000, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd0, 7'd1},
			1'b1, 32'h1},
		'{'{CMD_QUERY, 6'd0, 32'h0000_0000, C_ONE, C_ZERO, C_ZERO, C_ZERO, 6'd0, 7'd1},
			1'b1, 32'h0},
		'{'{CMD_QUERY, 6'd0, 32'h0000_0000, C_ZERO, C_ZERO, C_ZERO,
			COORD_WIDTH'(-2 * C_ONE), 6'd0, 7'd1}, 1'b1, 32'h1},
		// extreme coordinates against extreme entries
		'{'{CMD_QUERY, 6'd63, 32'h0000_0000, C_MIN, C_MAX, C_MIN, C_MAX, 6'd0, 7'd3},
			1'b0, 32'h0},
		'{'{CMD_QUERY, 6'd0, 32'hFFFF_FFDE, C_HALF, C_ZERO, C_ZERO, C_ZERO, 6'd0, 7'd3},
			1'b0, 32'h0},
		// first bit at 31, so the second entry falls off the top
		'{'{CMD_QUERY, 6'd0, 32'h0000_0001, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd31, 7'd2},
			1'b0, 32'h0},
		// base past 31 wraps the first bit
		'{'{CMD_QUERY, 6'd0, 32'h0000_0001, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 6'd33, 7'd1},
			1'b0, 32'h0},
		// end saturated to the table size
		'{'{CMD_QUERY, 6'd0, 32'h0000_0001, C_ZERO, C_ZERO, C_ZERO, 24'sd1, 6'd63, 7'd64},
			1'b0, 32'h0},
		'{'{CMD_QUERY, 6'd0, 32'h8000_0001, C_MAX, C_MAX, C_MAX, C_MIN, 6'd63, 7'd1},
			1'b0, 32'h0},
		// walk from zero up to the base
		'{'{CMD_QUERY, 6'd0, 32'h0000_0020, C_MAX, C_MIN, C_ZERO, C_MAX, 6'd3, 7'd0},
			1'b0, 32'h0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	// predictor copy of the sphere table
	logic [FLAG_W-1:0]             tbl_flags  [MAX_ENTRIES];
	logic signed [COORD_WIDTH-1:0] tbl_cx     [MAX_ENTRIES];
	logic signed [COORD_WIDTH-1:0] tbl_cy     [MAX_ENTRIES];
	logic signed [COORD_WIDTH-1:0] tbl_cz     [MAX_ENTRIES];
	logic signed [COORD_WIDTH-1:0] tbl_radius [MAX_ENTRIES];

	bit               gen_written [MAX_ENTRIES];	// slots already written by the stimulus
	logic [HIT_W-1:0] pending_hits [$];
	scripted_hit_t    scripted_hits [$];
	int               items_sent;
	int               mismatch_count;
	int               quiet_cycles;
	bit               tx_idle_on;
	bit               rx_idle_on;
	bit               long_hold_req;

	sphere_overlap_bitmask dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	// range of slots a query walks, end saturated to the table size
	function automatic void walk_bounds(request_t q, output int first, output int last);
		first = q.flag_bits[MASK_RANGE_BIT] ? int'(q.range_base) : 0;
		last = q.flag_bits[MASK_SINGLE_BIT] ? int'(q.range_base)
			: int'(q.range_base) + int'(q.range_count);
		if (last > MAX_ENTRIES)
			last = MAX_ENTRIES;
	endfunction

	function automatic logic [HIT_W-1:0] predict_hit_mask(request_t q);
		int first;
		int last;
		int bit_pos;
		longint dx;
		longint dy;
		longint dz;
		longint reach;
		logic [HIT_W-1:0] hits;
		hits = '0;
		walk_bounds(q, first, last);
		bit_pos = q.flag_bits[MASK_RANGE_BIT] ? int'(q.range_base) % HIT_W : 0;
		for (int i = first; i < last; i++) begin
			if ((tbl_flags[i] & q.flag_bits) == q.flag_bits) begin
				dx = longint'($signed(q.pos_x)) - longint'(tbl_cx[i]);
				dy = longint'($signed(q.pos_y)) - longint'(tbl_cy[i]);
				dz = longint'($signed(q.pos_z)) - longint'(tbl_cz[i]);
				reach = longint'(tbl_radius[i]) + longint'($signed(q.extent));
				// strictly inside; bits beyond the top are dropped
				if (dx * dx + dy * dy + dz * dz < reach * reach && bit_pos < HIT_W)
					hits[bit_pos] = 1'b1;
			end
			bit_pos++;
		end
		return hits;
	endfunction

	// mostly a small cluster around the origin so that hits are common
	function automatic logic signed [COORD_WIDTH-1:0] random_coord(bit near);
		case ($urandom_range(0, 19))
			0: return C_MAX;
			1: return C_MIN;
			default: return near ? COORD_WIDTH'(int'($urandom_range(0, 4000)) - 2000)
				: COORD_WIDTH'($urandom());
		endcase
	endfunction

	function automatic request_t random_write(logic [INDEX_FIELD_W-1:0] slot);
		request_t r;
		bit near;
		near = ($urandom_range(0, 3) != 0);
		r.command = CMD_WRITE;
		r.entry_index = slot;
		case ($urandom_range(0, 3))
			0: r.flag_bits = '1;
			1: r.flag_bits = $urandom();
			2: r.flag_bits = $urandom() | $urandom();
			default: r.flag_bits = ~($urandom() & $urandom() & $urandom());
		endcase
		r.pos_x = random_coord(near);
		r.pos_y = random_coord(near);
		r.pos_z = random_coord(near);
		r.extent = near ? COORD_WIDTH'(int'($urandom_range(0, 2500)) - 300) : random_coord(1'b0);
		r.range_base = BASE_W'($urandom_range(0, MAX_ENTRIES - 1));
		r.range_count = COUNT_W'($urandom_range(0, MAX_ENTRIES));
		return r;
	endfunction

	// offer one request, with an optional gap first, and hold it until taken
	task automatic send_request(request_t r, bit known, logic [HIT_W-1:0] hit);
		scripted_hits.push_back('{known, hit});
		if (r.command == CMD_WRITE)
			gen_written[r.entry_index] = 1'b1;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.command;
		s_tdata <= S_TDATA_W'({r.range_count, r.range_base, r.extent, r.pos_z, r.pos_y,
			r.pos_x, r.flag_bits, r.entry_index});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin : monitor
		request_t seen;
		scripted_hit_t scripted;
		logic [HIT_W-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.command = cmd_t'(s_tuser);
				{seen.range_count, seen.range_base, seen.extent, seen.pos_z, seen.pos_y,
					seen.pos_x, seen.flag_bits, seen.entry_index} = s_tdata[REQ_BITS-1:0];
				scripted = scripted_hits.pop_front();
				if (seen.command == CMD_WRITE) begin
					tbl_flags[seen.entry_index] = seen.flag_bits;
					tbl_cx[seen.entry_index] = seen.pos_x;
					tbl_cy[seen.entry_index] = seen.pos_y;
					tbl_cz[seen.entry_index] = seen.pos_z;
					tbl_radius[seen.entry_index] = seen.extent;
				end else begin
					pending_hits.push_back(scripted.known ? scripted.hit : predict_hit_mask(seen));
				end
			end
			if (m_tvalid && m_tready) begin
				if (pending_hits.size() == 0) begin
					report_mismatch($sformatf("hit_mask %h with no result expected", m_tdata));
				end else begin
					want = pending_hits.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("hit_mask %h, expected %h", m_tdata, want));
				end
			end
			// watchdog on cycles with no handshake on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("sphere_overlap_bitmask_tb: errors");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		request_t q;
		int first;
		int last;
		int next_switch;
		bit idle_block;
		bit hold_asked;
		bit drained;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		foreach (SCRIPT[i])
			send_request(SCRIPT[i].req, SCRIPT[i].known, SCRIPT[i].hit);

		// random part
		next_switch = 0;
		idle_block = 1'b1;
		hold_asked = 1'b0;
		drained = 1'b0;
		while (items_sent < ITEM_TARGET) begin
			// switch idling on and off in blocks, and drop it for the last stretch
			if (items_sent >= next_switch) begin
				idle_block = ($urandom_range(0, 3) != 0);
				next_switch = items_sent + 64;
			end
			if (!hold_asked && items_sent >= HOLD_AT) begin
				hold_asked = 1'b1;
				long_hold_req = 1'b1;
			end
			tx_idle_on = idle_block && items_sent < ITEM_TARGET - QUIET_TAIL
				&& !(items_sent >= HOLD_AT && items_sent < HOLD_AT + HOLD_SPAN);
			rx_idle_on = idle_block && items_sent < ITEM_TARGET - QUIET_TAIL;

			// pause once until every result is out
			if (!drained && items_sent >= DRAIN_AT) begin
				drained = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_hits.size() != 0) @(posedge clk);
			end

			if ($urandom_range(0, 9) < 4) begin
				send_request(random_write(INDEX_FIELD_W'($urandom_range(0, MAX_ENTRIES - 1))),
					1'b0, '0);
			end else begin
				q.command = CMD_QUERY;
				q.entry_index = INDEX_FIELD_W'($urandom());
				case ($urandom_range(0, 5))
					0: q.flag_bits = '0;
					1: q.flag_bits = $urandom() & $urandom() & $urandom();
					2: q.flag_bits = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
					3: q.flag_bits = $urandom();
					default: q.flag_bits = $urandom() & $urandom() & $urandom() & $urandom();
				endcase
				q.flag_bits[MASK_RANGE_BIT] = ($urandom_range(0, 9) < 4);
				q.flag_bits[MASK_SINGLE_BIT] = ($urandom_range(0, 19) < 3);
				idle_block = idle_block;
				first = $urandom_range(0, 3);	// near unless zero
				q.pos_x = random_coord(first != 0);
				q.pos_y = random_coord(first != 0);
				q.pos_z = random_coord(first != 0);
				q.extent = (first != 0) ? COORD_WIDTH'(int'($urandom_range(0, 800)) - 400)
					: random_coord(1'b0);
				q.range_base = BASE_W'($urandom_range(0, MAX_ENTRIES - 1));
				q.range_count = COUNT_W'($urandom_range(0, MAX_ENTRIES));
				// write every slot the walk will read before the query goes out
				walk_bounds(q, first, last);
				for (int i = first; i < last; i++)
					if (!gen_written[i])
						send_request(random_write(INDEX_FIELD_W'(i)), 1'b0, '0);
				send_request(q, 1'b0, '0);
			end
		end

		// drain and let the block settle
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sphere_overlap_bitmask_tb: clean");
		else
			$display("sphere_overlap_bitmask_tb: errors");
		$finish;
	end

endmodule
